// ----- design/smcd_pkg.sv -----
// Shared types and codes for the SPI motor command decoder.
// Used by smcd_decode and spi_motor_command_decoder_core; no dependencies.
package smcd_pkg;

  localparam int PhaseW  = 4;
  localparam int TargetW = 3;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 1;

  // Sequencer phases
  localparam logic [PhaseW-1:0] PH_COMMAND  = 4'd0;
  localparam logic [PhaseW-1:0] PH_RPM_HI   = 4'd1;
  localparam logic [PhaseW-1:0] PH_RPM_LO   = 4'd2;
  localparam logic [PhaseW-1:0] PH_VOLT_HI  = 4'd3;
  localparam logic [PhaseW-1:0] PH_VOLT_LO  = 4'd4;
  localparam logic [PhaseW-1:0] PH_CURRENT  = 4'd5;
  localparam logic [PhaseW-1:0] PH_PWM      = 4'd6;
  localparam logic [PhaseW-1:0] PH_SEND_ERR = 4'd7;
  localparam logic [PhaseW-1:0] PH_SEND_RHI = 4'd8;
  localparam logic [PhaseW-1:0] PH_SEND_RLO = 4'd9;
  localparam logic [PhaseW-1:0] PH_FINISH   = 4'd10;

  // Host command codes
  localparam logic [7:0] OPC_RUN         = 8'h01;
  localparam logic [7:0] OPC_HALT        = 8'h02;
  localparam logic [7:0] OPC_SPEED_WR    = 8'h03;
  localparam logic [7:0] OPC_SET_VOLTAGE = 8'h04;
  localparam logic [7:0] OPC_AMPS_WR     = 8'h05;
  localparam logic [7:0] OPC_STATUS_RD   = 8'h06;
  localparam logic [7:0] OPC_ALIVE       = 8'h07;
  localparam logic [7:0] OPC_DUTY_WR     = 8'h08;
  localparam logic [7:0] OPC_MEAS_PARAM  = 8'h09;
  localparam logic [7:0] OPC_MEASURE     = 8'h0A;
  localparam logic [7:0] OPC_GET_MEAS    = 8'h0B;

  // Mode requests
  localparam logic [ModeW-1:0] MODE_NONE  = 2'd0;
  localparam logic [ModeW-1:0] MODE_FREE  = 2'd1;
  localparam logic [ModeW-1:0] MODE_BRAKE = 2'd2;

  // Setting targets
  localparam logic [TargetW-1:0] TGT_NONE    = 3'd0;
  localparam logic [TargetW-1:0] TGT_RPM_HI  = 3'd1;
  localparam logic [TargetW-1:0] TGT_RPM_LO  = 3'd2;
  localparam logic [TargetW-1:0] TGT_VOLT_HI = 3'd3;
  localparam logic [TargetW-1:0] TGT_VOLT_LO = 3'd4;
  localparam logic [TargetW-1:0] TGT_CURRENT = 3'd5;
  localparam logic [TargetW-1:0] TGT_PWM     = 3'd6;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DUMMY = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ALIVE = 1'b1;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [7:0]  motor_mode;
    logic [7:0]  driver_errors;
    logic [15:0] measured_rpm;
  } item_t;

  typedef struct packed {
    logic               tx_load;
    logic [7:0]         tx_byte;
    logic [ModeW-1:0]   mode_request;
    logic [TargetW-1:0] setting_target;
    logic [7:0]         setting_value;
  } result_t;

endpackage

// ----- design/spi_motor_command_decoder_core.sv -----
// SPI motor command decoder, top level: input register, decode, result register.
// Depends on smcd_pkg and smcd_decode.
// The input register feeds the combinational decode, whose result is then registered in the result register.
// Throughput: one byte per cycle while out_stall does not hold the result register.
// Reset (rst, synchronous): phase to command phase, both config registers to 0,
// pipeline empty.
module spi_motor_command_decoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  input  logic [7:0]                   motor_mode,
  input  logic [7:0]                   driver_errors,
  input  logic [15:0]                  measured_rpm,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         tx_load,
  output logic [7:0]                   tx_byte,
  output logic [smcd_pkg::ModeW-1:0]   mode_request,
  output logic [smcd_pkg::TargetW-1:0] setting_target,
  output logic [7:0]                   setting_value,
  input  logic                         cfg_write,
  input  logic [smcd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);
  import smcd_pkg::*;

  logic [7:0]        dummy_byte;
  logic [7:0]        alive_byte;
  logic [PhaseW-1:0] phase;
  logic [PhaseW-1:0] phase_next;
  logic              s1_valid;
  item_t             s1_item;
  result_t           dec_result;
  result_t           res;
  logic              out_free;
  logic              s1_move;
  logic              in_take;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  smcd_decode u_decode (
    .phase      (phase),
    .item       (s1_item),
    .dummy_byte (dummy_byte),
    .alive_byte (alive_byte),
    .phase_next (phase_next),
    .result     (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dummy_byte <= 8'd0;
      alive_byte <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DUMMY: dummy_byte <= cfg_data;
        CFG_ALIVE: alive_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refill whenever the held byte moves on or the stage is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.rx_byte       <= rx_byte;
      s1_item.motor_mode    <= motor_mode;
      s1_item.driver_errors <= driver_errors;
      s1_item.measured_rpm  <= measured_rpm;
    end
  end

  // Advance the phase only when the decoded byte lands in the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COMMAND;
    end else if (s1_move) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res <= dec_result;
    end
  end

  assign tx_load        = res.tx_load;
  assign tx_byte        = res.tx_byte;
  assign mode_request   = res.mode_request;
  assign setting_target = res.setting_target;
  assign setting_value  = res.setting_value;

endmodule

// ----- design/smcd_decode.sv -----
// Phase and command decode for one received byte.
// Depends on smcd_pkg; pure combinational logic.
module smcd_decode (
  input  logic [smcd_pkg::PhaseW-1:0] phase,
  input  smcd_pkg::item_t             item,
  input  logic [7:0]                  dummy_byte,
  input  logic [7:0]                  alive_byte,
  output logic [smcd_pkg::PhaseW-1:0] phase_next,
  output smcd_pkg::result_t           result
);
  import smcd_pkg::*;

  logic               load;
  logic [7:0]         txb;
  logic [ModeW-1:0]   mreq;
  logic [TargetW-1:0] target;

  always_comb begin
    load       = 1'b0;
    txb        = 8'd0;
    mreq       = MODE_NONE;
    target     = TGT_NONE;
    phase_next = PH_COMMAND;
    case (phase)
      PH_RPM_HI: begin
        target     = TGT_RPM_HI;
        phase_next = PH_RPM_LO;
      end
      PH_RPM_LO:  target = TGT_RPM_LO;
      PH_VOLT_HI: begin
        target     = TGT_VOLT_HI;
        phase_next = PH_VOLT_LO;
      end
      PH_VOLT_LO: target = TGT_VOLT_LO;
      PH_CURRENT: target = TGT_CURRENT;
      PH_PWM:     target = TGT_PWM;
      PH_SEND_ERR: begin
        load       = 1'b1;
        txb        = item.driver_errors;
        phase_next = PH_SEND_RHI;
      end
      PH_SEND_RHI: begin
        load       = 1'b1;
        txb        = item.measured_rpm[15:8];
        phase_next = PH_SEND_RLO;
      end
      PH_SEND_RLO: begin
        load       = 1'b1;
        txb        = item.measured_rpm[7:0];
        phase_next = PH_FINISH;
      end
      PH_FINISH: begin
        load = 1'b1;
        txb  = dummy_byte;
      end
      default: begin
        // Command phase; unused phase codes decode as commands too
        case (item.rx_byte)
          OPC_RUN, OPC_MEASURE: begin
            mreq = MODE_FREE;
            load = 1'b1;
            txb  = dummy_byte;
          end
          OPC_HALT: begin
            mreq = MODE_BRAKE;
            load = 1'b1;
            txb  = dummy_byte;
          end
          OPC_SPEED_WR: begin
            phase_next = PH_RPM_HI;
            load       = 1'b1;
            txb        = dummy_byte;
          end
          OPC_SET_VOLTAGE: begin
            phase_next = PH_VOLT_HI;
            load       = 1'b1;
            txb        = dummy_byte;
          end
          OPC_AMPS_WR: begin
            phase_next = PH_CURRENT;
            load       = 1'b1;
            txb        = dummy_byte;
          end
          OPC_STATUS_RD: begin
            phase_next = PH_SEND_ERR;
            load       = 1'b1;
            txb        = item.motor_mode;
          end
          OPC_ALIVE: begin
            phase_next = PH_FINISH;
            load       = 1'b1;
            txb        = alive_byte;
          end
          OPC_DUTY_WR: phase_next = PH_PWM;
          default: ;
        endcase
      end
    endcase

    result.tx_load        = load;
    result.tx_byte        = txb;
    result.mode_request   = mreq;
    result.setting_target = target;
    result.setting_value  = (target != TGT_NONE) ? item.rx_byte : 8'd0;
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for spi_motor_command_decoder_core: directed table, then random
// command sequences checked against an in-bench model of the byte sequencer.
// Depends on smcd_pkg and the decoder RTL only.
module testbench;
  import smcd_pkg::*;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = '0;
  logic [7:0]         motor_mode = '0;
  logic [7:0]         driver_errors = '0;
  logic [15:0]        measured_rpm = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               tx_load;
  logic [7:0]         tx_byte;
  logic [ModeW-1:0]   mode_request;
  logic [TargetW-1:0] setting_target;
  logic [7:0]         setting_value;
  logic               cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_DUMMY;
  logic [7:0]         cfg_data = '0;

  // Sequencer model state
  logic [PhaseW-1:0] seq_phase = PH_COMMAND;
  logic [7:0]        dummy_shadow = '0;
  logic [7:0]        alive_shadow = '0;

  result_t  pending_decodes[$];
  dir_row_t directed_rows[$];
  bit       no_idle = 1'b0;
  int       hold_request = 0;
  int       mismatches = 0;

  spi_motor_command_decoder_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .rx_byte(rx_byte), .motor_mode(motor_mode),
    .driver_errors(driver_errors), .measured_rpm(measured_rpm),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_load(tx_load), .tx_byte(tx_byte), .mode_request(mode_request),
    .setting_target(setting_target), .setting_value(setting_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one host byte and advance the phase.
  function automatic result_t decode_host_byte(input item_t it);
    result_t r;
    r = '0;
    case (seq_phase)
      PH_RPM_HI: begin
        r.setting_target = TGT_RPM_HI;
        seq_phase = PH_RPM_LO;
      end
      PH_RPM_LO: begin
        r.setting_target = TGT_RPM_LO;
        seq_phase = PH_COMMAND;
      end
      PH_VOLT_HI: begin
        r.setting_target = TGT_VOLT_HI;
        seq_phase = PH_VOLT_LO;
      end
      PH_VOLT_LO: begin
        r.setting_target = TGT_VOLT_LO;
        seq_phase = PH_COMMAND;
      end
      PH_CURRENT: begin
        r.setting_target = TGT_CURRENT;
        seq_phase = PH_COMMAND;
      end
      PH_PWM: begin
        r.setting_target = TGT_PWM;
        seq_phase = PH_COMMAND;
      end
      PH_SEND_ERR: begin
        r.tx_load = 1'b1;
        r.tx_byte = it.driver_errors;
        seq_phase = PH_SEND_RHI;
      end
      PH_SEND_RHI: begin
        r.tx_load = 1'b1;
        r.tx_byte = it.measured_rpm[15:8];
        seq_phase = PH_SEND_RLO;
      end
      PH_SEND_RLO: begin
        r.tx_load = 1'b1;
        r.tx_byte = it.measured_rpm[7:0];
        seq_phase = PH_FINISH;
      end
      PH_FINISH: begin
        r.tx_load = 1'b1;
        r.tx_byte = dummy_shadow;
        seq_phase = PH_COMMAND;
      end
      default: begin
        seq_phase = PH_COMMAND;
        case (it.rx_byte)
          OPC_RUN, OPC_MEASURE: begin
            r.mode_request = MODE_FREE;
            r.tx_load = 1'b1;
            r.tx_byte = dummy_shadow;
          end
          OPC_HALT: begin
            r.mode_request = MODE_BRAKE;
            r.tx_load = 1'b1;
            r.tx_byte = dummy_shadow;
          end
          OPC_SPEED_WR, OPC_SET_VOLTAGE, OPC_AMPS_WR: begin
            if (it.rx_byte == OPC_SPEED_WR) seq_phase = PH_RPM_HI;
            else if (it.rx_byte == OPC_SET_VOLTAGE) seq_phase = PH_VOLT_HI;
            else seq_phase = PH_CURRENT;
            r.tx_load = 1'b1;
            r.tx_byte = dummy_shadow;
          end
          OPC_STATUS_RD: begin
            seq_phase = PH_SEND_ERR;
            r.tx_load = 1'b1;
            r.tx_byte = it.motor_mode;
          end
          OPC_ALIVE: begin
            seq_phase = PH_FINISH;
            r.tx_load = 1'b1;
            r.tx_byte = alive_shadow;
          end
          OPC_DUTY_WR: seq_phase = PH_PWM;
          default: ;
        endcase
      end
    endcase
    if (r.setting_target != TGT_NONE) r.setting_value = it.rx_byte;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_row(input logic [7:0] rx, input logic [7:0] mode,
                                  input logic [7:0] errs, input logic [15:0] rpm,
                                  input logic typed, input logic load,
                                  input logic [7:0] txb, input logic [ModeW-1:0] mreq,
                                  input logic [TargetW-1:0] tgt, input logic [7:0] val);
    dir_row_t row;
    row.it = '{rx_byte: rx, motor_mode: mode, driver_errors: errs, measured_rpm: rpm};
    row.typed = typed;
    row.res = '{tx_load: load, tx_byte: txb, mode_request: mreq,
                setting_target: tgt, setting_value: val};
    directed_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // Offer one byte; hold it until the transfer, then queue what it should decode to.
  task automatic offer_item(input item_t it, input logic typed, input result_t typed_res);
    result_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    rx_byte       <= it.rx_byte;
    motor_mode    <= it.motor_mode;
    driver_errors <= it.driver_errors;
    measured_rpm  <= it.measured_rpm;
    do @(posedge clk); while (in_stall);
    predicted = decode_host_byte(it);
    pending_decodes.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_decodes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dummy_val, input logic [7:0] alive_val);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DUMMY;
    cfg_data  <= dummy_val;
    @(posedge clk);
    dummy_shadow = dummy_val;
    cfg_index <= CFG_ALIVE;
    cfg_data  <= alive_val;
    @(posedge clk);
    alive_shadow = alive_val;
    cfg_write <= 1'b0;
  endtask

  // Stimulus
  initial begin : sender
    item_t it;
    int    r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(8'hFF, 8'h00);
    add_row(OPC_RUN,         8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_FREE,  TGT_NONE, 8'h00);
    add_row(OPC_HALT,        8'hFF, 8'hFF, 16'hFFFF, 1, 1, 8'hFF, MODE_BRAKE, TGT_NONE, 8'h00);
    add_row(OPC_MEASURE,     8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_FREE,  TGT_NONE, 8'h00);
    add_row(OPC_MEAS_PARAM,  8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(OPC_GET_MEAS,    8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'h00,           8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'hFF,           8'hFF, 8'hFF, 16'hFFFF, 1, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'h0C,           8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(OPC_SPEED_WR,    8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'hFF,           8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE, TGT_RPM_HI, 8'hFF);
    add_row(8'h00,           8'hFF, 8'hFF, 16'hFFFF, 1, 0, 8'h00, MODE_NONE, TGT_RPM_LO, 8'h00);
    add_row(OPC_SET_VOLTAGE, 8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_NONE,  TGT_NONE, 8'h00);
    // command codes in a data phase are plain data
    add_row(OPC_HALT,        8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE, TGT_VOLT_HI, OPC_HALT);
    add_row(8'h80,           8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE, TGT_VOLT_LO, 8'h80);
    add_row(OPC_AMPS_WR,     8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'h7F,           8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE, TGT_CURRENT, 8'h7F);
    add_row(OPC_DUTY_WR,     8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'hFF,           8'h00, 8'h00, 16'h0000, 1, 0, 8'h00, MODE_NONE,  TGT_PWM, 8'hFF);
    add_row(OPC_STATUS_RD,   8'hFF, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_NONE,  TGT_NONE, 8'h00);
    // reply phases ignore the received byte
    add_row(OPC_HALT,        8'h00, 8'h5A, 16'h0000, 0, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(OPC_SPEED_WR,    8'h00, 8'h00, 16'h00FF, 0, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(8'hFF,           8'h00, 8'h00, 16'h00FF, 0, 0, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(OPC_RUN,         8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(OPC_ALIVE,       8'h00, 8'h00, 16'h0000, 1, 1, 8'h00, MODE_NONE,  TGT_NONE, 8'h00);
    add_row(OPC_ALIVE,       8'h00, 8'h00, 16'h0000, 1, 1, 8'hFF, MODE_NONE,  TGT_NONE, 8'h00);
    foreach (directed_rows[i])
      offer_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
    drain_decodes();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(8'h00, 8'hFF);
        1: set_config(8'hFF, 8'hFF);
        2: set_config(8'h00, 8'h00);
        default: set_config(pick_byte(), pick_byte());
      endcase
      no_idle = (ph == 3);
      // stall the result side for a long stretch while bytes keep coming
      if (ph == 4) hold_request = 120;
      for (int n = 0; n < 200; n++) begin
        it.motor_mode    = pick_byte();
        it.driver_errors = pick_byte();
        it.measured_rpm  = {pick_byte(), pick_byte()};
        r = $urandom_range(0, 99);
        if (seq_phase == PH_COMMAND && r < 80)
          it.rx_byte = 8'($urandom_range(OPC_RUN, OPC_GET_MEAS));
        else
          it.rx_byte = pick_byte();
        offer_item(it, 1'b0, '0);
      end
      drain_decodes();
    end
    no_idle = 1'b0;

    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        note_mismatch("result with nothing pending", 0, 1);
      end else begin
        want = pending_decodes.pop_front();
        if (tx_load !== want.tx_load) note_mismatch("tx_load", want.tx_load, tx_load);
        if (tx_byte !== want.tx_byte) note_mismatch("tx_byte", want.tx_byte, tx_byte);
        if (mode_request !== want.mode_request)
          note_mismatch("mode_request", want.mode_request, mode_request);
        if (setting_target !== want.setting_target)
          note_mismatch("setting_target", want.setting_target, setting_target);
        if (setting_value !== want.setting_value)
          note_mismatch("setting_value", want.setting_value, setting_value);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
